FILE: design/rwc_pkg.sv
package rwc_pkg;

  // texture geometry (powers of two)
  localparam int unsigned TEX_W      = 64;
  localparam int unsigned TEX_H      = 64;
  localparam int unsigned TEX_W_LOG2 = $clog2(TEX_W);
  localparam int unsigned TEX_H_LOG2 = $clog2(TEX_H);

  // serial divider sizes
  localparam int unsigned DVD_W   = 41;
  localparam int unsigned DVS_W   = 29;
  localparam int unsigned DCNT_W  = $clog2(DVD_W);

  localparam logic [23:0] M24      = 24'hFFFFFF;
  localparam logic [11:0] MAX_HGT  = 12'd2048;

  // configuration register indexes
  localparam logic [1:0] CFG_HEIGHT  = 2'd0;
  localparam logic [1:0] CFG_CEILING = 2'd1;
  localparam logic [1:0] CFG_FLOOR   = 2'd2;

  typedef enum logic [2:0] {
    REG_CEIL  = 3'd0,
    REG_WALL  = 3'd1,
    REG_FLOOR = 3'd2,
    REG_DEPTH = 3'd3,
    REG_NOCOL = 3'd4
  } rwc_region_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEPTH,
    ST_LINE_GO,
    ST_LINE,
    ST_STEP_GO,
    ST_STEP,
    ST_POS,
    ST_OUT
  } rwc_state_e;

  typedef struct packed {
    logic               is_col;
    logic [10:0]        col;
    logic               side;
    logic [7:0]         cx;
    logic [7:0]         cy;
    logic [1:0]         sx;
    logic [1:0]         sy;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [23:0]        px;
    logic [23:0]        py;
  } rwc_item_t;

  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row;
    rwc_region_e region;
    logic [23:0] color;
    logic [5:0]  tx;
    logic [5:0]  ty;
    logic        dk;
    logic [23:0] depth;
    logic        last;
  } rwc_res_t;

  typedef struct packed {
    logic        col_valid;
    logic [10:0] wall_start;
    logic [10:0] wall_end;
    logic        div_busy;
    logic        div_start;
  } rwc_stat_t;

endpackage

FILE: design/rwc_front.sv
module rwc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [119:0]       in_data_i,
  input  logic               in_user_i,
  output rwc_pkg::rwc_item_t item_o,
  output logic               item_valid_o,
  input  logic               item_pop_i
);
  import rwc_pkg::*;

  rwc_item_t  fifo_q [2];
  rwc_item_t  item_in;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  // unpack and classify the incoming transfer
  always_comb begin
    item_in.is_col = !in_user_i;
    item_in.col    = in_data_i[10:0];
    item_in.side   = in_data_i[11];
    item_in.cx     = in_data_i[19:12];
    item_in.cy     = in_data_i[27:20];
    item_in.sx     = in_data_i[29:28];
    item_in.sy     = in_data_i[31:30];
    item_in.dx     = $signed(in_data_i[49:32]);
    item_in.dy     = $signed(in_data_i[67:50]);
    item_in.px     = in_data_i[91:68];
    item_in.py     = in_data_i[115:92];
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];

  // two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (item_pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(item_pop_i);
    end
  end

endmodule

FILE: design/rwc_div.sv
module rwc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rwc_pkg::DVD_W-1:0] dvd_i,
  input  logic [rwc_pkg::DVS_W-1:0] dvs_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [rwc_pkg::DVD_W-1:0] quo_o
);
  import rwc_pkg::*;

  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DVS_W:0]    trial;
  logic              ge;
  logic [DVS_W-1:0]  rem_nx;

  // one restoring step per cycle
  always_comb begin
    trial  = {rem_q, quo_q[DVD_W-1]};
    ge     = (trial >= {1'b0, dvs_q});
    rem_nx = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dvd_i;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: design/rwc_back.sv
module rwc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rwc_pkg::rwc_item_t item_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  input  logic [11:0]        heff_i,
  input  logic [23:0]        ceil_i,
  input  logic [23:0]        floor_i,
  output rwc_pkg::rwc_res_t  res_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output rwc_pkg::rwc_stat_t stat_o
);
  import rwc_pkg::*;

  rwc_state_e state_q, state_d;

  // committed column state
  logic        col_valid_q, col_valid_d;
  logic [10:0] act_col_q;
  logic [10:0] row_q;
  logic [10:0] ws_q, we_q;
  logic [5:0]  tcol_q;
  logic [23:0] tstep_q;
  logic [31:0] tpos_q;
  logic        side_q;

  // column set-up working registers
  logic [10:0]        pcol_q;
  logic               pside_q, dneg_q, dzero_q, mirror_q;
  logic signed [17:0] odir_q;
  logic [23:0]        opos_q;
  logic [23:0]        depth_q;
  logic signed [42:0] prod_q;
  logic [DVS_W-1:0]   lh_q;
  logic [10:0]        pws_q, pwe_q;
  logic [27:0]        toff_q;
  logic [31:0]        frac_q;
  logic [23:0]        pstep_q;
  logic [31:0]        ppos_q;
  logic [5:0]         ptcol_q;

  rwc_res_t res_q, res_d;
  logic     res_valid_q, res_load, out_free;

  // divider hookup
  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0] div_dvs;

  // column item decode
  logic [7:0]         c_cell;
  logic               c_off;
  logic [23:0]        c_pos;
  logic signed [17:0] c_dir;
  logic [8:0]         c_co;
  logic signed [26:0] c_num;
  logic [26:0]        c_mag;
  logic [17:0]        c_dmag;

  // set-up arithmetic
  logic [10:0]  half_h;
  logic [27:0]  half_l;
  logic [28:0]  e_sum;
  logic [51:0]  pos_full;
  logic [5:0]   tx_raw;

  // row decode
  logic       row_in, row_last, row_pop, col_pop;
  logic [5:0] row_ty;

  rwc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dvd_i  (div_dvd),
    .dvs_i  (div_dvs),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign out_free = !res_valid_q || res_ready_i;

  // ray distance numerator and divisor from a column item
  always_comb begin
    c_cell = item_i.side ? item_i.cy : item_i.cx;
    c_off  = item_i.side ? item_i.sy[1] : item_i.sx[1];
    c_pos  = item_i.side ? item_i.py : item_i.px;
    c_dir  = item_i.side ? item_i.dy : item_i.dx;
    c_co   = {1'b0, c_cell} + 9'(c_off);
    c_num  = $signed({2'b00, c_co, 16'h0000}) - $signed({3'b000, c_pos});
    c_mag  = c_num[26] ? 27'(-c_num) : 27'(c_num);
    c_dmag = c_dir[17] ? 18'(-c_dir) : 18'(c_dir);
  end

  // set-up helpers
  always_comb begin
    half_h   = heff_i[11:1];
    half_l   = lh_q[DVS_W-1:1];
    e_sum    = {18'h0, half_h} + {1'b0, half_l};
    pos_full = toff_q * pstep_q;
    tx_raw   = frac_q[31 -: TEX_W_LOG2];
  end

  // row pixel
  always_comb begin
    row_in   = col_valid_q && ({1'b0, row_q} < heff_i);
    row_last = ({1'b0, row_q} == 12'(heff_i - 12'd1));
    row_ty   = tpos_q[16 +: TEX_H_LOG2];
  end

  // sequencer: next state, queue pop, result load, divider start
  always_comb begin
    state_d   = state_q;
    row_pop   = 1'b0;
    col_pop   = 1'b0;
    res_load  = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    res_d     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i && !item_i.is_col && out_free) begin
          row_pop  = 1'b1;
          res_load = 1'b1;
          if (row_in) begin
            res_d.col  = act_col_q;
            res_d.row  = row_q;
            res_d.last = row_last;
            if (row_q < ws_q) begin
              res_d.region = REG_CEIL;
              res_d.color  = ceil_i;
            end else if (row_q > we_q) begin
              res_d.region = REG_FLOOR;
              res_d.color  = floor_i;
            end else begin
              res_d.region = REG_WALL;
              res_d.tx     = tcol_q;
              res_d.ty     = row_ty;
              res_d.dk     = side_q;
            end
          end else begin
            res_d.region = REG_NOCOL;
          end
        end else if (item_valid_i && item_i.is_col) begin
          col_pop   = 1'b1;
          div_start = 1'b1;
          div_dvd   = {c_mag[24:0], 16'h0000};
          div_dvs   = DVS_W'(c_dmag);
          state_d   = ST_DEPTH;
        end
      end
      ST_DEPTH:   if (div_done) state_d = ST_LINE_GO;
      ST_LINE_GO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({heff_i, 16'h0000});
        div_dvs   = (depth_q == 24'h0) ? DVS_W'(1) : DVS_W'(depth_q);
        state_d   = ST_LINE;
      end
      ST_LINE:    if (div_done) state_d = ST_STEP_GO;
      ST_STEP_GO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(TEX_H) << 16;
        div_dvs   = lh_q;
        state_d   = ST_STEP;
      end
      ST_STEP:    if (div_done) state_d = ST_POS;
      ST_POS:     state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          res_load     = 1'b1;
          res_d.col    = pcol_q;
          res_d.region = REG_DEPTH;
          res_d.depth  = depth_q;
          state_d      = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  assign item_pop_o = row_pop || col_pop;

  // column state update
  always_comb begin
    col_valid_d = col_valid_q;
    if (row_pop && (!row_in || row_last)) col_valid_d = 1'b0;
    if (state_q == ST_OUT && out_free) col_valid_d = (heff_i != 12'h0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_valid_q <= col_valid_d;
      res_valid_q <= res_load || (res_valid_q && !res_ready_i);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
  end

  // column set-up datapath and row bookkeeping
  always_ff @(posedge clk_i) begin
    if (col_pop) begin
      pcol_q   <= item_i.col;
      pside_q  <= item_i.side;
      dneg_q   <= (c_num[26] ^ c_dir[17]) && (c_num != 27'sd0);
      dzero_q  <= (c_dir == 18'sd0);
      odir_q   <= item_i.side ? item_i.dx : item_i.dy;
      opos_q   <= item_i.side ? item_i.px : item_i.py;
      mirror_q <= item_i.side ? item_i.dy[17]
                              : (!item_i.dx[17] && item_i.dx != 18'sd0);
    end
    if (state_q == ST_DEPTH && div_done) begin
      if (dzero_q)                      depth_q <= M24;
      else if (dneg_q)                  depth_q <= 24'h0;
      else if (div_quo[DVD_W-1:24] != '0) depth_q <= M24;
      else                              depth_q <= div_quo[23:0];
    end
    if (state_q == ST_LINE_GO) begin
      prod_q <= $signed({1'b0, depth_q}) * odir_q;
    end
    if (state_q == ST_LINE && div_done) begin
      lh_q <= (div_quo == '0) ? DVS_W'(1) : div_quo[DVS_W-1:0];
    end
    if (state_q == ST_STEP_GO) begin
      pws_q  <= (half_l >= 28'(half_h)) ? 11'h0 : 11'(28'(half_h) - half_l);
      pwe_q  <= (e_sum >= 29'(heff_i)) ? 11'(heff_i - 12'd1) : 11'(e_sum);
      toff_q <= (half_l >= 28'(half_h)) ? 28'(half_l - 28'(half_h)) : 28'h0;
      frac_q <= {opos_q[15:0], 16'h0000} + prod_q[31:0];
    end
    if (state_q == ST_STEP && div_done) begin
      pstep_q <= (div_quo > DVD_W'(M24)) ? M24 : div_quo[23:0];
    end
    if (state_q == ST_POS) begin
      ppos_q  <= pos_full[31:0];
      ptcol_q <= mirror_q ? 6'(TEX_W - 1) - tx_raw : tx_raw;
    end
    // commit the new column with its depth record
    if (state_q == ST_OUT && out_free) begin
      act_col_q <= pcol_q;
      side_q    <= pside_q;
      row_q     <= 11'h0;
      ws_q      <= pws_q;
      we_q      <= pwe_q;
      tcol_q    <= ptcol_q;
      tstep_q   <= pstep_q;
      tpos_q    <= ppos_q;
    end
    // advance one row
    if (row_pop && row_in) begin
      if (!row_last) row_q <= row_q + 11'd1;
      if (row_q >= ws_q && row_q <= we_q) tpos_q <= tpos_q + {8'h0, tstep_q};
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_comb begin
    stat_o.col_valid  = col_valid_q;
    stat_o.wall_start = ws_q;
    stat_o.wall_end   = we_q;
    stat_o.div_busy   = div_busy;
    stat_o.div_start  = div_start;
  end

endmodule

FILE: design/raycast_wall_column.sv
// Textured wall column renderer for a grid raycaster. A column transfer
// (tuser 0) carries one ray and returns a depth record with the saturated
// perpendicular distance; each following row transfer (tuser 1) returns the
// next pixel from the top: ceiling colour, wall texel coordinates with a
// darken flag, or floor colour, and tlast on the final row (or a no-column
// result if no column is active). A row result passes through the queue and
// then the result register; rows stream at one pixel per clock while the
// output is ready and no column set-up runs. A column set-up runs three
// successive divisions in the single shared divider that resolves one
// quotient bit per cycle. A two-entry queue sits in front, and a result
// register lets the input keep flowing while a result waits. The user must
// write configuration only while the block is idle; it is not enforced.
module raycast_wall_column (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // column_x[10:0] hit_side[11] cell_x[19:12] cell_y[27:20] sign_x[29:28]
  // sign_y[31:30] dir_x[49:32] dir_y[67:50] pos_x[91:68] pos_y[115:92]
  input  logic [119:0] s_axis_tdata,
  // req_type[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_column[10:0] out_row[21:11] pixel_color[45:22] texel_x[51:46]
  // texel_y[57:52] darken[58] depth[82:59]
  output logic [87:0]  m_axis_tdata,
  // region[2:0]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import rwc_pkg::*;

  logic [11:0] height_q;
  logic [23:0] ceil_q, floor_q;
  logic [11:0] heff;
  rwc_item_t   item;
  logic        item_valid, item_pop;
  rwc_res_t    res;
  rwc_stat_t   stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 12'd480;
      ceil_q   <= 24'h0;
      floor_q  <= 24'h0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEIGHT:  height_q <= cfg_data_i[11:0];
        CFG_CEILING: ceil_q   <= cfg_data_i;
        CFG_FLOOR:   floor_q  <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  assign heff = (height_q > MAX_HGT) ? MAX_HGT : height_q;

  rwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop)
  );

  rwc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_pop_o  (item_pop),
    .heff_i      (heff),
    .ceil_i      (ceil_q),
    .floor_i     (floor_q),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .stat_o      (stat)
  );

  // output packing
  assign m_axis_tdata = {5'h0, res.depth, res.dk, res.ty, res.tx, res.color,
                         res.row, res.col};
  assign m_axis_tuser = res.region;
  assign m_axis_tlast = res.last;

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_wall_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.col_valid |-> stat.wall_start <= stat.wall_end)
    else $error("wall start beyond wall end");

  a_nocol_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == REG_NOCOL) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("no-column result carries data");

endmodule
